// File: design/ekvc_pkg.sv
// shared types and constants of the expiring key-value cache
`default_nettype none
package ekvc_pkg;

	localparam int unsigned ENTRIES_DEF = 16;
	localparam logic [31:0] EXPIRE_RESET = 32'd60;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_SET = 1'b1;

	typedef struct packed {
		logic        func;
		logic [31:0] key;
		logic [31:0] value;
		logic [31:0] now;
	} req_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic [1:0]  status;
		logic [4:0]  entries_in_use;
	} rsp_t;

	// lookup word passed from cell to cell
	typedef struct packed {
		logic        vld;
		logic [31:0] key;
		logic [31:0] now;
		logic        hit;
		logic [31:0] data;
		logic        free;
	} tok_t;

	// update broadcast to all cells once the lookup word leaves the chain
	typedef struct packed {
		logic        en;
		logic        ins;
		logic        set;
		logic [31:0] key;
		logic [31:0] data;
		logic [31:0] now;
	} wb_t;

endpackage
`default_nettype wire

// File: design/ekvc_cell.sv
// one table slot: expiry check, key compare and update of its own entry
`default_nettype none
module ekvc_cell
	import ekvc_pkg::*;
#(
	parameter int unsigned ENTRIES = ENTRIES_DEF,
	parameter int unsigned IDX     = 0,
	localparam int unsigned IW     = $clog2(ENTRIES),
	localparam int unsigned CW     = $clog2(ENTRIES + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [31:0]   expire,
	input  wire tok_t          tok_i,
	input  wire logic [IW-1:0] hidx_i,
	input  wire logic [IW-1:0] fidx_i,
	input  wire logic [CW-1:0] cnt_i,
	input  wire wb_t           wb,
	input  wire logic [IW-1:0] wb_idx,
	output tok_t               tok_o,
	output logic [IW-1:0]      hidx_o,
	output logic [IW-1:0]      fidx_o,
	output logic [CW-1:0]      cnt_o
);

	logic          valid_q;
	logic [31:0]   key_q;
	logic [31:0]   data_q;
	logic [31:0]   time_q;
	tok_t          tok_q;
	logic [IW-1:0] hidx_q;
	logic [IW-1:0] fidx_q;
	logic [CW-1:0] cnt_q;

	logic expired;
	logic live;
	logic match;
	logic free_here;
	logic wb_mine;

	// age counts as zero when time runs backwards
	assign expired   = valid_q && (tok_i.now >= time_q) && ((tok_i.now - time_q) > expire);
	assign live      = valid_q && !expired;
	assign match     = live && (key_q == tok_i.key) && !tok_i.hit;
	assign free_here = !live && !tok_i.free;
	assign wb_mine   = wb.en && (wb_idx == IW'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q.vld  <= tok_i.vld;
			tok_q.key  <= tok_i.key;
			tok_q.now  <= tok_i.now;
			tok_q.hit  <= tok_i.hit || match;
			tok_q.data <= match ? data_q : tok_i.data;
			tok_q.free <= tok_i.free || free_here;
			if (tok_i.vld && expired) begin
				valid_q <= 1'b0;
			end else if (wb_mine && wb.ins) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		hidx_q <= match ? IW'(IDX) : hidx_i;
		fidx_q <= free_here ? IW'(IDX) : fidx_i;
		cnt_q  <= CW'(cnt_i + CW'(live));
		if (wb_mine) begin
			time_q <= wb.now;
			if (wb.set) begin
				data_q <= wb.data;
			end
			if (wb.ins) begin
				key_q <= wb.key;
			end
		end
	end

	assign tok_o  = tok_q;
	assign hidx_o = hidx_q;
	assign fidx_o = fidx_q;
	assign cnt_o  = cnt_q;

endmodule
`default_nettype wire

// File: design/expiring_key_value_cache_unit.sv
// top level of the expiring key-value cache: request control and the row of slots
//
// request channel: a word on req is taken at a clock edge with start high and
// busy low; req carries get or set, key, value and the current time in seconds.
// the lookup word then walks the row of ENTRIES slots, one slot per cycle;
// each slot drops itself if its idle age exceeds expire_seconds, compares its
// key and reports whether it is free. after the last slot the hit or the
// lowest free slot is written, and the result word appears on rsp with done
// high for exactly one cycle once the lookup word has left the last slot.
// busy is low again during that done cycle, so a new request can be taken at
// its closing edge; no new request is taken while one is still in the slot row.
// the result cannot be held off by the receiver.
// cfg channel: cfg_data is written into expire_seconds when cfg_valid and
// cfg_ready are high; cfg_ready is high whenever no request is in flight.
// reset empties every slot, sets expire_seconds to 60 and drops any request.
`default_nettype none
module expiring_key_value_cache_unit
	import ekvc_pkg::*;
#(
	parameter int unsigned ENTRIES = ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire req_t        req,
	output logic             done,
	output rsp_t             rsp,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);

	localparam int unsigned IW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);

	logic        busy_q;
	logic        done_q;
	rsp_t        rsp_q;
	logic [31:0] expire_q;
	logic        func_q;
	logic [31:0] value_q;
	tok_t        launch_q;

	tok_t          tok_w  [0:ENTRIES];
	logic [IW-1:0] hidx_w [0:ENTRIES];
	logic [IW-1:0] fidx_w [0:ENTRIES];
	logic [CW-1:0] cnt_w  [0:ENTRIES];

	wb_t           wb;
	logic [IW-1:0] wb_idx;
	tok_t          tail;
	logic          accept;
	logic          insert;
	logic [CW-1:0] cnt_next;
	rsp_t          rsp_next;

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			launch_q <= '0;
			expire_q <= EXPIRE_RESET;
		end else begin
			launch_q.vld <= accept;
			done_q       <= tail.vld;
			if (accept) begin
				launch_q.key  <= req.key;
				launch_q.now  <= req.now;
				launch_q.hit  <= 1'b0;
				launch_q.data <= 32'd0;
				launch_q.free <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail.vld) begin
				busy_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				expire_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= req.func;
			value_q <= req.value;
		end
		if (tail.vld) begin
			rsp_q <= rsp_next;
		end
	end

	assign tok_w[0]  = launch_q;
	assign hidx_w[0] = '0;
	assign fidx_w[0] = '0;
	assign cnt_w[0]  = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		ekvc_cell #(
			.ENTRIES (ENTRIES),
			.IDX     (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.expire (expire_q),
			.tok_i  (tok_w[i]),
			.hidx_i (hidx_w[i]),
			.fidx_i (fidx_w[i]),
			.cnt_i  (cnt_w[i]),
			.wb     (wb),
			.wb_idx (wb_idx),
			.tok_o  (tok_w[i+1]),
			.hidx_o (hidx_w[i+1]),
			.fidx_o (fidx_w[i+1]),
			.cnt_o  (cnt_w[i+1])
		);
	end

	assign tail   = tok_w[ENTRIES];
	assign insert = (func_q == FUNC_SET) && !tail.hit && tail.free;

	always_comb begin
		wb.en    = tail.vld && (tail.hit || insert);
		wb.ins   = !tail.hit;
		wb.set   = (func_q == FUNC_SET);
		wb.key   = tail.key;
		wb.data  = value_q;
		wb.now   = tail.now;
		wb_idx   = tail.hit ? hidx_w[ENTRIES] : fidx_w[ENTRIES];
		cnt_next = CW'(cnt_w[ENTRIES] + CW'(insert));
		rsp_next.read_value     = 32'd0;
		rsp_next.entries_in_use = 5'(cnt_next);
		if (func_q == FUNC_SET) begin
			rsp_next.status = (tail.hit || tail.free) ? ST_OK : ST_FULL;
		end else if (tail.hit) begin
			rsp_next.status     = ST_OK;
			rsp_next.read_value = tail.data;
		end else begin
			rsp_next.status = ST_MISS;
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign rsp       = rsp_q;
	assign cfg_ready = !busy_q;

endmodule
`default_nettype wire

// File: design/ekvc_check.sv
// port-level checks of the cache handshake and results, bound to the top level
`default_nettype none
module ekvc_check
	import ekvc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire rsp_t rsp,
	input wire logic cfg_ready
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepting a request");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy still high while result shown");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_value_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.read_value != 32'd0) |-> rsp.status == ST_OK)
		else $error("nonzero read value without a hit");

	a_cfg_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> cfg_ready)
		else $error("config port not ready while idle");

endmodule

bind expiring_key_value_cache_unit ekvc_check u_ekvc_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.rsp       (rsp),
	.cfg_ready (cfg_ready)
);
`default_nettype wire

// File: bench/tb.sv
// testbench for the expiring key-value cache: directed and random requests against a predictor
`timescale 1ns / 100ps
module tb;
	import ekvc_pkg::*;

	localparam int N_SLOTS     = ENTRIES_DEF;
	localparam int SETTLE      = 4;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 140;
	localparam int POOL_KEYS   = 20;

	typedef struct packed {
		logic        is_cfg;
		logic [31:0] cfg_word;
		req_t        req;
	} job_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic        busy;
	req_t        req       = '0;
	logic        done;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data  = '0;

	// predictor copy of the cache
	logic        slot_live  [N_SLOTS];
	logic [31:0] slot_key   [N_SLOTS];
	logic [31:0] slot_data  [N_SLOTS];
	logic [31:0] slot_stamp [N_SLOTS];
	int          live_total = 0;
	logic [31:0] expire_cur = EXPIRE_RESET;

	job_t request_backlog[$];
	rsp_t lookups_due[$];
	int   accepted      = 0;
	int   settle_cycles = 0;
	int   stall_cycles  = 0;
	int   mismatches    = 0;

	expiring_key_value_cache_unit #(.ENTRIES(N_SLOTS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < N_SLOTS; i++) begin
			slot_live[i] = 1'b0;
		end
	end

	// age out, look up, then apply the get or set; returns the response word
	function automatic rsp_t cache_access(req_t r);
		rsp_t o;
		int   hit_idx;
		int   free_idx;
		int   slot;
		o = '0;
		hit_idx = -1;
		free_idx = -1;
		for (int i = 0; i < N_SLOTS; i++) begin
			// a stamp ahead of now counts as age zero
			if (slot_live[i] && r.now >= slot_stamp[i] &&
			    (r.now - slot_stamp[i]) > expire_cur) begin
				slot_live[i] = 1'b0;
				live_total--;
			end
		end
		for (int i = 0; i < N_SLOTS; i++) begin
			if (slot_live[i]) begin
				if (hit_idx < 0 && slot_key[i] == r.key)
					hit_idx = i;
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		if (r.func == FUNC_GET) begin
			if (hit_idx >= 0) begin
				slot_stamp[hit_idx] = r.now;
				o.read_value = slot_data[hit_idx];
				o.status = ST_OK;
			end else begin
				o.status = ST_MISS;
			end
		end else begin
			slot = hit_idx;
			if (slot < 0 && free_idx >= 0) begin
				slot = free_idx;
				slot_live[slot] = 1'b1;
				slot_key[slot] = r.key;
				live_total++;
			end
			if (slot >= 0) begin
				slot_data[slot] = r.value;
				slot_stamp[slot] = r.now;
				o.status = ST_OK;
			end else begin
				o.status = ST_FULL;
			end
		end
		o.entries_in_use = live_total[4:0];
		return o;
	endfunction

	task automatic push_req(logic f, logic [31:0] k, logic [31:0] v, logic [31:0] t);
		job_t j;
		j = '0;
		j.req.func = f;
		j.req.key = k;
		j.req.value = v;
		j.req.now = t;
		request_backlog.push_back(j);
	endtask

	task automatic push_cfg(logic [31:0] w);
		job_t j;
		j = '0;
		j.is_cfg = 1'b1;
		j.cfg_word = w;
		request_backlog.push_back(j);
	endtask

	// one expiry setting, a small key pool so the slots fill and hit
	task automatic random_phase(logic [31:0] expiry, logic [31:0] t0);
		logic [31:0] pool [POOL_KEYS];
		longint      t;
		longint      step;
		longint      span;
		int          r;
		logic [31:0] k;
		pool[0] = 32'h0000_0000;
		pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_KEYS; i++)
			pool[i] = $urandom();
		push_cfg(expiry);
		t = t0;
		span = (expiry > 8) ? expiry / 8 : 1;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				step = 0;
			else if (r < 85)
				step = $urandom_range(0, span);
			else if (r < 95)
				step = longint'(expiry) + $urandom_range(0, 1);
			else
				step = -longint'($urandom_range(0, 3));
			t = t + step;
			if (t < 0)
				t = 0;
			if (t > 64'hFFFF_FFFF)
				t = 64'hFFFF_FFFF;
			k = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_KEYS - 1)]
			                                 : $urandom();
			push_req(($urandom_range(0, 99) < 55) ? FUNC_SET : FUNC_GET, k, $urandom(),
			         t[31:0]);
		end
	endtask

	// driver: holds a word until it is taken, config only once the cache is quiet
	always @(posedge clk or negedge arst_n) begin : drive_blk
		job_t head;
		logic take_req;
		logic take_cfg;
		logic drive_req;
		logic drive_cfg;
		logic idle;
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			cfg_valid <= 1'b0;
			cfg_data <= '0;
		end else begin
			take_req = start && !busy;
			take_cfg = cfg_valid && cfg_ready;
			if (take_req) begin
				head = request_backlog.pop_front();
				lookups_due.push_back(cache_access(head.req));
				accepted++;
			end
			if (take_cfg) begin
				head = request_backlog.pop_front();
				expire_cur = head.cfg_word;
				settle_cycles = 0;
			end
			idle = !(accepted >= 300 && accepted < 500) && ($urandom_range(0, 99) < 9);
			drive_req = start && !take_req;
			drive_cfg = cfg_valid && !take_cfg;
			if (!drive_req && !drive_cfg && request_backlog.size() > 0) begin
				head = request_backlog[0];
				if (head.is_cfg) begin
					if (lookups_due.size() == 0 && !busy && !take_req)
						settle_cycles++;
					else
						settle_cycles = 0;
					drive_cfg = !idle && settle_cycles >= SETTLE;
					if (drive_cfg)
						cfg_data <= head.cfg_word;
				end else begin
					drive_req = !idle;
					if (drive_req)
						req <= head.req;
				end
			end
			start <= drive_req;
			cfg_valid <= drive_cfg;
		end
	end

	always @(posedge clk) begin : check_blk
		rsp_t want;
		if (arst_n && done) begin
			if (lookups_due.size() == 0) begin
				$display("%0t: unexpected word read_value=%h status=%0d entries_in_use=%0d",
				         $time, rsp.read_value, rsp.status, rsp.entries_in_use);
				mismatches++;
			end else begin
				want = lookups_due.pop_front();
				if (rsp.read_value !== want.read_value || rsp.status !== want.status ||
				    rsp.entries_in_use !== want.entries_in_use) begin
					$display("%0t: expected read_value=%h status=%0d entries_in_use=%0d",
					         $time, want.read_value, want.status, want.entries_in_use);
					$display("%0t: actual   read_value=%h status=%0d entries_in_use=%0d",
					         $time, rsp.read_value, rsp.status, rsp.entries_in_use);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving anywhere
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		// empty cache, both key extremes, then the expiry boundary at the reset value
		push_req(FUNC_GET, 32'h0000_0000, 32'h1234_5678, 32'd0);
		push_req(FUNC_SET, 32'h0000_0000, 32'h0000_0000, 32'd0);
		push_req(FUNC_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		push_req(FUNC_GET, 32'h0000_0000, 32'h0000_0000, 32'd10);
		push_req(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000, 32'd60);
		push_req(FUNC_SET, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'd60);
		push_req(FUNC_GET, 32'h0000_0000, 32'h0000_0000, 32'd71);
		// time stepping back keeps the entry
		push_req(FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd30);
		for (int i = 1; i < N_SLOTS; i++)
			push_req(FUNC_SET, i, ~i, 32'd30);
		// table full: set refused, get misses
		push_req(FUNC_SET, 32'h8000_0000, 32'h5A5A_5A5A, 32'd30);
		push_req(FUNC_GET, 32'h8000_0000, 32'h0000_0000, 32'd30);
		// zero expiry keeps only entries of age zero
		push_cfg(32'd0);
		push_req(FUNC_SET, 32'h8000_0000, 32'h0F0F_0F0F, 32'd30);
		push_req(FUNC_GET, 32'd3, 32'h0000_0000, 32'd31);

		random_phase(32'd0, 32'd40);
		random_phase(32'd1, $urandom());
		random_phase(32'd5, 32'd0);
		random_phase(32'd100, $urandom());
		random_phase(32'hFFFF_FFFF, 32'hFFFF_FF00);
		random_phase($urandom_range(2, 1000), $urandom());
		random_phase(EXPIRE_RESET, 32'd1000);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (request_backlog.size() > 0 || lookups_due.size() > 0)
			@(posedge clk);
		repeat (N_SLOTS + 4) @(posedge clk);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
